// ----- rtl/core/trfd_pkg.sv -----
// Shared constants, types and helpers for the terminal receive FIFO device.
package trfd_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Longest drain: 32 beats of 4 bytes.
    localparam logic [31:0] MAX_DRAIN_BYTES = 32'd128;

    // Register offsets
    localparam logic [9:0] OFS_PUT_CHAR    = 10'h000;
    localparam logic [9:0] OFS_BYTES_READY = 10'h004;
    localparam logic [9:0] OFS_CMD         = 10'h008;
    localparam logic [9:0] OFS_PTR         = 10'h010;
    localparam logic [9:0] OFS_LEN         = 10'h014;

    // Modes
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;

    // Commands
    localparam logic [31:0] CMD_IRQ_OFF = 32'd0;
    localparam logic [31:0] CMD_IRQ_ON  = 32'd1;
    localparam logic [31:0] CMD_TX_DMA  = 32'd2;
    localparam logic [31:0] CMD_DRAIN   = 32'd3;

    // Result kinds
    localparam logic [2:0] K_ACK   = 3'd0;
    localparam logic [2:0] K_READ  = 3'd1;
    localparam logic [2:0] K_TX    = 3'd2;
    localparam logic [2:0] K_TXDMA = 3'd3;
    localparam logic [2:0] K_BEAT  = 3'd4;
    localparam logic [2:0] K_ERR   = 3'd5;

    // Error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OFFSET   = 3'd1;
    localparam logic [2:0] ERR_COMMAND  = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_LOAD = 4'b0100,
        S_PUSH = 4'b1000
    } state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] read_data;
        logic [7:0]  tx_byte;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
        logic [2:0]  beat_bytes;
        logic [31:0] tx_length;
        logic [2:0]  error_code;
        logic        irq;
        logic        last;
    } result_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ----- rtl/core/trfd_if.sv -----
// Valid/ready channel interfaces for the device's event and result streams.
interface trfd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [9:0]  reg_offset;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;

    modport source (output valid, output mode, output reg_offset, output write_data,
                    output rx_byte, input ready);
    modport sink   (input valid, input mode, input reg_offset, input write_data,
                    input rx_byte, output ready);
endinterface

interface trfd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] read_data;
    logic [7:0]  tx_byte;
    logic [31:0] mem_address;
    logic [31:0] mem_data;
    logic [2:0]  beat_bytes;
    logic [31:0] tx_length;
    logic [2:0]  error_code;
    logic        irq;
    logic        last;

    modport source (output valid, output kind, output read_data, output tx_byte,
                    output mem_address, output mem_data, output beat_bytes,
                    output tx_length, output error_code, output irq, output last,
                    input ready);
    modport sink   (input valid, input kind, input read_data, input tx_byte,
                    input mem_address, input mem_data, input beat_bytes,
                    input tx_length, input error_code, input irq, input last,
                    output ready);
endinterface

// ----- rtl/core/trfd_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
module trfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/tty_receive_fifo_device_core.sv -----
// Register-mapped terminal device: receive FIFO, byte count, irq enable and DMA drain.
//
// Channels: "item" carries one event per beat (bus write, bus read or received
// byte); "result" carries the answers, the final one of each event marked with
// last. Every event gives one result, except a non-empty drain within bounds,
// which gives one memory-write beat per 4 FIFO bytes, the last beat possibly fewer.
// Results: a single-result event shows its result the cycle after it is taken;
// with the receiver ready and no drain running, an event can be taken every cycle.
// Drain: the FIFO is a byte-wide RAM; each byte is read in S_READ (address),
// then S_LOAD (registered data), and each beat is handed over in S_PUSH.
// One event is processed at a time; no new event is taken until the drain
// has handed over its last beat, so FIFO reads never overlap receive writes.
// Reset clears the byte count, irq enable, DMA pointer/length and the FIFO
// pointers; the RAM contents are not cleared and need no clearing pass.
// When the receiver stalls, the result register holds its beat and the block
// stops taking events; a drain still fetches the bytes of its next beat, then
// waits until the held beat is taken.
module tty_receive_fifo_device_core
    import trfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    trfd_in_if.sink      item,
    trfd_out_if.source   result
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             irq_en_reg, irq_en_next;
    logic [31:0]      ptr_reg, ptr_next;
    logic [31:0]      len_reg, len_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [1:0]       lane_reg, lane_next;
    logic [31:0]      word_reg, word_next;
    logic [31:0]      addr_reg, addr_next;
    logic             drain_irq_reg, drain_irq_next;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg, res_next;

    logic             item_fire;
    logic             out_free;
    logic             load;
    logic             ram_we;
    logic [7:0]       ram_rdata;

    assign out_free  = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == S_IDLE) && out_free;
    assign item_fire = item.valid && item.ready;

    trfd_ram #(
        .WIDTH(8),
        .DEPTH(FIFO_DEPTH)
    ) u_fifo_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(tail_reg),
        .wdata(item.rx_byte),
        .raddr(head_reg),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        irq_en_next    = irq_en_reg;
        ptr_next       = ptr_reg;
        len_next       = len_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        rem_next       = rem_reg;
        lane_next      = lane_reg;
        word_next      = word_reg;
        addr_next      = addr_reg;
        drain_irq_next = drain_irq_reg;
        res_next       = res_reg;
        load           = 1'b0;
        ram_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    res_next      = '0;
                    res_next.kind = K_ACK;
                    res_next.last = 1'b1;
                    load          = 1'b1;
                    case (item.mode)
                        MODE_WRITE:
                        begin
                            case (item.reg_offset)
                                OFS_PUT_CHAR:
                                begin
                                    res_next.kind    = K_TX;
                                    res_next.tx_byte = item.write_data[7:0];
                                end
                                OFS_CMD:
                                begin
                                    case (item.write_data)
                                        CMD_IRQ_OFF: irq_en_next = 1'b0;
                                        CMD_IRQ_ON:  irq_en_next = 1'b1;
                                        CMD_TX_DMA:
                                        begin
                                            res_next.kind        = K_TXDMA;
                                            res_next.mem_address = ptr_reg;
                                            res_next.tx_length   = len_reg;
                                        end
                                        CMD_DRAIN:
                                        begin
                                            if (len_reg > 32'(count_reg) ||
                                                len_reg > MAX_DRAIN_BYTES)
                                            begin
                                                res_next.kind       = K_ERR;
                                                res_next.error_code = ERR_TOO_LONG;
                                            end
                                            else if (len_reg != 32'd0)
                                            begin
                                                // Count is committed now; head walks
                                                // forward byte by byte.
                                                load       = 1'b0;
                                                count_next = count_reg - len_reg[CNT_W-1:0];
                                                rem_next   = len_reg[CNT_W-1:0];
                                                lane_next  = '0;
                                                word_next  = '0;
                                                addr_next  = ptr_reg;
                                                state_next = S_READ;
                                            end
                                        end
                                        default:
                                        begin
                                            res_next.kind       = K_ERR;
                                            res_next.error_code = ERR_COMMAND;
                                        end
                                    endcase
                                end
                                OFS_PTR: ptr_next = item.write_data;
                                OFS_LEN: len_next = item.write_data;
                                default:
                                begin
                                    res_next.kind       = K_ERR;
                                    res_next.error_code = ERR_OFFSET;
                                end
                            endcase
                        end
                        MODE_READ:
                        begin
                            if (item.reg_offset == OFS_BYTES_READY)
                            begin
                                res_next.kind      = K_READ;
                                res_next.read_data = 32'(count_reg);
                            end
                            else
                            begin
                                res_next.kind       = K_ERR;
                                res_next.error_code = ERR_OFFSET;
                            end
                        end
                        MODE_RX:
                        begin
                            if (count_reg >= CNT_W'(FIFO_DEPTH))
                            begin
                                res_next.kind       = K_ERR;
                                res_next.error_code = ERR_OVERFLOW;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                tail_next  = next_ptr(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    res_next.irq   = irq_en_next && (count_next != '0);
                    drain_irq_next = irq_en_next && (count_next != '0);
                end
            end
            S_READ:
            begin
                head_next  = next_ptr(head_reg);
                rem_next   = rem_reg - 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                word_next[8*lane_reg +: 8] = ram_rdata;
                if (lane_reg == 2'd3 || rem_reg == '0)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    lane_next  = lane_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    load                 = 1'b1;
                    res_next             = '0;
                    res_next.kind        = K_BEAT;
                    res_next.mem_address = addr_reg;
                    res_next.mem_data    = word_reg;
                    res_next.beat_bytes  = 3'({1'b0, lane_reg}) + 3'd1;
                    res_next.irq         = drain_irq_reg;
                    res_next.last        = (rem_reg == '0);
                    addr_next            = addr_reg + 32'd4;
                    word_next            = '0;
                    lane_next            = '0;
                    state_next           = (rem_reg == '0) ? S_IDLE : S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            irq_en_reg    <= 1'b0;
            ptr_reg       <= '0;
            len_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            rem_reg       <= '0;
            lane_reg      <= '0;
            drain_irq_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            irq_en_reg    <= irq_en_next;
            ptr_reg       <= ptr_next;
            len_reg       <= len_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            rem_reg       <= rem_next;
            lane_reg      <= lane_next;
            drain_irq_reg <= drain_irq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = res_reg.kind;
    assign result.read_data   = res_reg.read_data;
    assign result.tx_byte     = res_reg.tx_byte;
    assign result.mem_address = res_reg.mem_address;
    assign result.mem_data    = res_reg.mem_data;
    assign result.beat_bytes  = res_reg.beat_bytes;
    assign result.tx_length   = res_reg.tx_length;
    assign result.error_code  = res_reg.error_code;
    assign result.irq         = res_reg.irq;
    assign result.last        = res_reg.last;

endmodule

// ----- rtl/core/trfd_checker.sv -----
// Port-level checks for the terminal FIFO device, bound to the device core.
module trfd_checker
    import trfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [2:0]  result_kind,
    input logic [2:0]  result_beat_bytes,
    input logic [31:0] result_mem_data,
    input logic        result_last
);

    logic item_fire;
    logic result_fire;
    logic pending_reg;

    assign item_fire   = item_valid && item_ready;
    assign result_fire = result_valid && result_ready;

    // An event is open from its beat until its last result beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (item_fire)
        begin
            pending_reg <= 1'b1;
        end
        else if (result_fire && result_last)
        begin
            pending_reg <= 1'b0;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_kind) && $stable(result_mem_data) &&
            $stable(result_last))
        else $error("result beat changed while stalled");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |-> !pending_reg || (result_fire && result_last))
        else $error("event taken before previous event finished");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg)
        else $error("result with no open event");

    a_beat_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((result_kind == K_BEAT) ?
                (result_beat_bytes != 3'd0 && result_beat_bytes <= 3'd4) :
                (result_beat_bytes == 3'd0)))
        else $error("beat byte count inconsistent with kind");

endmodule

bind tty_receive_fifo_device_core trfd_checker u_trfd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_valid       (item.valid),
    .item_ready       (item.ready),
    .result_valid     (result.valid),
    .result_ready     (result.ready),
    .result_kind      (result.kind),
    .result_beat_bytes(result.beat_bytes),
    .result_mem_data  (result.mem_data),
    .result_last      (result.last)
);
